>>> rtl/swm_pkg.sv
// Shared constants for the sliding window maximum block.
// No dependencies; imported by the top level.
`default_nettype none

package swm_pkg;

    // Default number of samples the chain can hold.
    localparam int WINDOW_MAX_DEF  = 64;
    // Default sample width in bits.
    localparam int SAMPLE_BITS_DEF = 16;
    // Width of the window size register.
    localparam int CFG_BITS        = 7;
    // Window size after reset.
    localparam int WIN_SIZE_RESET  = 1;

    // Width of the register that holds the window size.
    typedef logic [CFG_BITS-1:0] t_cfg_word;

endpackage : swm_pkg

`default_nettype wire

>>> rtl/swm_cell.sv
// One cell of the running maximum chain.
// Standalone; instantiated in a row by sliding_window_max_top.
`default_nettype none

module swm_cell #(
    parameter int SampleBits = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic [SampleBits-1:0] i_sample,
    input  wire logic [SampleBits-1:0] i_prev,
    output logic      [SampleBits-1:0] o_hold,
    output logic      [SampleBits-1:0] o_next
);

    logic [SampleBits-1:0] r_hold;

    // Cell i holds the maximum over the i+1 newest samples: the new sample
    // against what the left neighbor held over one sample fewer.
    assign o_next = (i_prev > i_sample) ? i_prev : i_sample;

    // Payload register, loaded on every accepted request.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hold <= o_next;
        end
    end

    assign o_hold = r_hold;

endmodule : swm_cell

`default_nettype wire

>>> rtl/sliding_window_max_top.sv
// Sliding window maximum: top level with the cell chain, fill counter,
// window size register and output register. Depends on swm_pkg and swm_cell.
//
// Usage:
//   Samples enter on the s_axis channel; s_axis_tuser high marks the first
//   sample of a new sequence. Each accepted request shifts the sample into a
//   row of WINDOW_MAX cells, where cell i keeps the maximum of the i+1 newest
//   samples. Once the current sequence holds at least window_size samples,
//   every accepted sample yields one result on m_axis: the maximum of the
//   newest window_size samples. Earlier samples yield nothing.
//   A result is valid on m_axis in the cycle after its sample is accepted.
//   Throughput: one sample per clock while m_axis keeps up (one compare per cell).
//   The output register frees the input side as soon as it is taken, so a
//   new request is accepted in the same cycle a waiting result leaves.
//   When the receiver stalls, the result holds and s_axis_tready falls.
//   window_size is written through i_cfg_we/i_cfg_wdata; zero acts as one,
//   values above WINDOW_MAX act as WINDOW_MAX. Reset (i_rst_n low, sync)
//   empties the window, sets window_size to 1 and drops any pending result.
`default_nettype none

module sliding_window_max_top
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int DataBits   = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Input channel.
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [DataBits-1:0] s_axis_tdata,   // [SAMPLE_BITS-1:0] sample
    input  wire logic                s_axis_tuser,   // [0] start_req
    // Output channel.
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic      [DataBits-1:0] m_axis_tdata,   // [SAMPLE_BITS-1:0] max_value
    // Window size register.
    input  wire logic                i_cfg_we,
    input  wire t_cfg_word           i_cfg_wdata
);

    localparam int FillBits = $clog2(WINDOW_MAX + 1);
    localparam int SelBits  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    logic [SAMPLE_BITS-1:0] sample;
    logic                   accept;
    logic [SAMPLE_BITS-1:0] cell_hold [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] cell_next [WINDOW_MAX];

    logic [FillBits-1:0]    r_fill;
    logic [FillBits-1:0]    n_fill;
    logic [FillBits-1:0]    r_win_len;
    logic [FillBits-1:0]    n_win_len;
    logic [FillBits-1:0]    win_len_m1;
    logic [SelBits-1:0]     sel;
    logic [31:0]            cfg_wide;
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_data;

    assign sample        = s_axis_tdata[SAMPLE_BITS-1:0];
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Row of cells; the first cell sees the sample on both inputs.
    for (genvar gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
        logic [SAMPLE_BITS-1:0] prev;
        if (gi == 0) begin : g_head
            assign prev = sample;
        end else begin : g_body
            assign prev = cell_hold[gi-1];
        end
        swm_cell #(
            .SampleBits (SAMPLE_BITS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_en     (accept),
            .i_sample (sample),
            .i_prev   (prev),
            .o_hold   (cell_hold[gi]),
            .o_next   (cell_next[gi])
        );
    end

    // Clamp the written window size into 1..WINDOW_MAX.
    assign cfg_wide = 32'(i_cfg_wdata);
    always_comb begin
        if (cfg_wide == 32'd0) begin
            n_win_len = FillBits'(1);
        end else if (cfg_wide > 32'(WINDOW_MAX)) begin
            n_win_len = FillBits'(WINDOW_MAX);
        end else begin
            n_win_len = cfg_wide[FillBits-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len <= FillBits'(WIN_SIZE_RESET);
        end else if (i_cfg_we) begin
            r_win_len <= n_win_len;
        end
    end

    // Samples held in the current sequence, saturating at WINDOW_MAX.
    always_comb begin
        if (s_axis_tuser) begin
            n_fill = FillBits'(1);
        end else if (r_fill == FillBits'(WINDOW_MAX)) begin
            n_fill = r_fill;
        end else begin
            n_fill = r_fill + FillBits'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (accept) begin
            r_fill <= n_fill;
        end
    end

    // The cell at position window_size-1 carries the result.
    assign win_len_m1 = r_win_len - FillBits'(1);
    assign sel        = win_len_m1[SelBits-1:0];

    // Output register: loaded on accept, cleared once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= (n_fill >= r_win_len);
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= cell_next[sel];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = DataBits'(r_out_data);

    // A result only appears right after an accepted sample.
    a_result_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(accept))
        else $error("result appeared without an accepted sample");

    // A start request restarts the fill count at one.
    a_start_restarts_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && s_axis_tuser) |=> (r_fill == FillBits'(1)))
        else $error("start request did not restart the fill count");

    // Fill count and window length stay in range.
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill <= FillBits'(WINDOW_MAX)) && (r_win_len != '0)
        && (r_win_len <= FillBits'(WINDOW_MAX)))
        else $error("fill count or window length out of range");

    // No result while the sequence is shorter than the window.
    a_no_short_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (n_fill < r_win_len)) |=> !r_out_valid)
        else $error("result made before the window was full");

endmodule : sliding_window_max_top

`default_nettype wire

>>> test/tb_sliding_window_max_top.sv
// Self-checking testbench for sliding_window_max_top: a scoreboard class predicts the
// running window maximum once the window is full and checks each result in order.
// Depends on swm_pkg and the RTL of sliding_window_max_top.
`default_nettype none

module tb_sliding_window_max_top
    import swm_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH = WINDOW_MAX_DEF;
    localparam int PTR_BITS   = $clog2(RING_DEPTH);

    // Predicts the window maximum and holds the maxima still to come out.
    class window_max_scoreboard;
        logic [15:0]         sample_ring [RING_DEPTH];
        int unsigned         held;
        logic [PTR_BITS-1:0] wr_ptr;
        t_cfg_word           win_reg;
        logic [15:0]         expected_max_q [$];
        int unsigned         errors;

        function new();
            held    = 0;
            wr_ptr  = '0;
            win_reg = t_cfg_word'(WIN_SIZE_RESET);
            errors  = 0;
        endfunction

        function void set_window(t_cfg_word value);
            win_reg = value;
        endfunction

        function int unsigned pending();
            return expected_max_q.size();
        endfunction

        // An accepted request: store the sample and, once the window is full, predict.
        function void note_request(logic [15:0] value, logic start);
            int unsigned         span;
            logic [PTR_BITS-1:0] pos;
            logic [15:0]         best;
            if (start) begin
                held   = 0;
                wr_ptr = '0;
            end
            sample_ring[wr_ptr] = value;
            wr_ptr = wr_ptr + 1'b1;
            if (held < RING_DEPTH) held++;
            // Zero acts as one, oversized values clamp to the ring depth.
            if (win_reg == 0) span = 1;
            else if (win_reg > RING_DEPTH) span = RING_DEPTH;
            else span = win_reg;
            if (held < span) return;
            pos  = wr_ptr - PTR_BITS'(span);
            best = sample_ring[pos];
            for (int i = 0; i < span; i++) begin
                if (sample_ring[pos] >= best) best = sample_ring[pos];
                pos = pos + 1'b1;
            end
            expected_max_q = {expected_max_q, best};
        endfunction

        // An accepted result: compare against the oldest prediction.
        function void check_result(logic [15:0] actual);
            logic [15:0] want;
            if (expected_max_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, actual);
                errors++;
                return;
            end
            want = expected_max_q[0];
            expected_max_q.delete(0);
            if (actual !== want) begin
                $display("%0t: max_value mismatch, expected %h, actual %h",
                         $time, want, actual);
                errors++;
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      s_axis_tvalid;
    logic      s_axis_tready;
    logic [15:0] s_axis_tdata;   // [15:0] sample
    logic      s_axis_tuser;     // [0] start_req
    logic      m_axis_tvalid;
    logic      m_axis_tready;
    logic [15:0] m_axis_tdata;   // [15:0] max_value
    logic      i_cfg_we;
    t_cfg_word i_cfg_wdata;

    // Shared between the sender and the receiver process.
    bit calm;
    bit hold_off_req;

    window_max_scoreboard wmax_sb = new();

    sliding_window_max_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog for a hung run.
    initial begin
        #2_000_000;
        $display("tb_sliding_window_max_top: FAIL");
        $finish;
    end

    // Sample both channels at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) wmax_sb.check_result(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready) wmax_sb.note_request(s_axis_tdata, s_axis_tuser);
        end
    end

    // Result receiver: random stalls, calm stretches and one long hold-off.
    initial begin : result_sink
        int unsigned stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req && stall_left == 0) begin
                stall_left   = 250;
                hold_off_req = 1'b0;
            end
            if (stall_left != 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (calm) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= 10);
            end
        end
    end

    // Offer one sample request; called and returns at a falling edge.
    task automatic send_sample(input logic [15:0] value, input logic start);
        if (!calm) begin
            while ($urandom_range(99) < 10) begin
                s_axis_tvalid <= 1'b0;
                @(negedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= start;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // Stop offering and wait until every predicted result has come out.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (wmax_sb.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Window size write; only issued while the block is idle.
    task automatic write_window(input t_cfg_word value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        wmax_sb.set_window(value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Mix of small values for ties, extremes and full-range values.
    function automatic logic [15:0] pick_sample();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 20) return 16'($urandom_range(3));
        if (r < 28) return 16'hFFFF;
        if (r < 33) return 16'h0000;
        return 16'($urandom);
    endfunction

    // One random phase of sequences at the current window size.
    task automatic run_phase(input int unsigned span, input int unsigned target);
        int unsigned sent;
        int unsigned seq_len;
        bit          resume;
        sent   = 0;
        // Sometimes carry on with the sequence from the previous phase.
        resume = ($urandom_range(99) < 30);
        while (sent < target) begin
            if ($urandom_range(99) < 80) seq_len = span + $urandom_range(30);
            else seq_len = $urandom_range(span, 1);
            for (int i = 0; i < seq_len; i++) begin
                send_sample(pick_sample(), (i == 0) && !resume);
                sent++;
            end
            resume = 1'b0;
        end
    endtask

    initial begin : stimulus
        t_cfg_word   sizes [14];
        int unsigned span;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        calm          = 1'b0;
        hold_off_req  = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset window of one, no start request yet.
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h1234, 1'b0);
        drain_results();

        // Window of three: a short sequence, then ties and extremes.
        write_window(7'd3);
        send_sample(16'h0005, 1'b1);
        send_sample(16'h0007, 1'b0);
        send_sample(16'h0009, 1'b1);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h0001, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h0000, 1'b0);
        drain_results();

        // Size zero behaves as one.
        write_window(7'd0);
        send_sample(16'h00FF, 1'b1);
        send_sample(16'hAAAA, 1'b0);
        send_sample(16'h5555, 1'b0);
        drain_results();

        // Oversized window mid-sequence: nothing until it fills.
        write_window(7'd127);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h0002, 1'b0);
        send_sample(16'hFFFE, 1'b0);
        drain_results();

        // Shrink mid-sequence: results resume at once.
        write_window(7'd2);
        send_sample(16'h0003, 1'b0);
        send_sample(16'h0004, 1'b0);
        drain_results();

        // Random phases over a spread of window sizes.
        sizes = '{7'd1, 7'd64, 7'd5, 7'd127, 7'd0, 7'd2, 7'd65,
                  7'd17, 7'd33, 7'd3, 7'd0, 7'd0, 7'd0, 7'd0};
        for (int p = 10; p < 14; p++) sizes[p] = t_cfg_word'($urandom_range(127));
        for (int p = 0; p < 14; p++) begin
            write_window(sizes[p]);
            if (sizes[p] == 0) span = 1;
            else if (sizes[p] > RING_DEPTH) span = RING_DEPTH;
            else span = sizes[p];
            calm = (p == 1);
            // Long receiver hold-off while the sender keeps offering.
            if (p == 3) hold_off_req = 1'b1;
            run_phase(span, 40);
            drain_results();
        end
        calm = 1'b0;

        repeat (10) @(negedge i_clk);
        if (wmax_sb.errors == 0 && wmax_sb.pending() == 0) begin
            $display("tb_sliding_window_max_top: PASS");
        end else begin
            $display("tb_sliding_window_max_top: FAIL");
        end
        $finish;
    end

endmodule : tb_sliding_window_max_top

`default_nettype wire
